// ----- rtl/rcfs_pkg.sv -----
// Shared constants for the rotate/crop frame sampler.
// Field widths, Q-format shift, register indexes and default geometry.
// No dependencies.
`default_nettype none

package rcfs_pkg;

  // Fixed field widths
  localparam int CMD_W       = 1;
  localparam int LOAD_ADDR_W = 17;
  localparam int PIX_W       = 16;
  localparam int X_W         = 8;
  localparam int Y_W         = 7;
  localparam int DEST_W      = 15;
  localparam int TRIG_W      = 16;

  // Q2.14 fraction bits of the trig registers
  localparam int Q_SHIFT = 14;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIN = 2'd1;

  localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SIN_RESET = 16'sd0;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b1;

  // Default geometry
  localparam int DEF_SRC_WIDTH  = 320;
  localparam int DEF_SRC_HEIGHT = 240;
  localparam int DEF_WIN_WIDTH  = 160;
  localparam int DEF_WIN_HEIGHT = 120;

endpackage

`default_nettype wire

// ----- rtl/rcfs_ram.sv -----
// Generic simple dual-read RAM: one write port, two registered read ports.
// Holds the frame store; no dependencies.
`default_nettype none

module rcfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output      logic [WIDTH-1:0]         rd_data_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output      logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/rotate_crop_frame_sampler_top.sv -----
// Rotate/crop frame sampler top level: pipeline around the frame store.
// Depends on rcfs_pkg and rcfs_ram.
//
// Accepts one command per clock (busy is low except in reset). A load writes one RGB565
// pixel into the SRC_WIDTH x SRC_HEIGHT frame store; a sample of window pixel (x,y)
// returns, on the result ports, the source pixel at the floored rotated position one row
// below, the unrotated centre-crop pixel and the mirrored window index, all on one
// result_valid cycle. The receiver cannot stall: every result shows for exactly one cycle.
// The pipeline has five registers (input, products, coordinates, address, store read); the
// frame store has one write and two read ports, so one item per clock is sustained. Loads
// reach the store at the same stage as sample reads, so all accesses keep transfer order.
// Samples outside the window and loads beyond the store give no result. The store has no
// reset and no clearing pass: read only pixels that were loaded. Rotated or crop addresses
// outside the store read as zero.
`default_nettype none

module rotate_crop_frame_sampler_top
  import rcfs_pkg::*;
#(
  parameter int SRC_WIDTH  = DEF_SRC_WIDTH,
  parameter int SRC_HEIGHT = DEF_SRC_HEIGHT,
  parameter int WIN_WIDTH  = DEF_WIN_WIDTH,
  parameter int WIN_HEIGHT = DEF_WIN_HEIGHT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // command channel
  input  wire logic                   start,
  output      logic                   busy,
  input  wire logic [CMD_W-1:0]       command,
  input  wire logic [LOAD_ADDR_W-1:0] load_address,
  input  wire logic [PIX_W-1:0]       pixel_value,
  input  wire logic [X_W-1:0]         out_x,
  input  wire logic [Y_W-1:0]         out_y,
  // configuration channel
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [TRIG_W-1:0]      cfg_data,
  // result channel
  output      logic                   result_valid,
  output      logic [PIX_W-1:0]       rotated_pixel,
  output      logic [PIX_W-1:0]       cropped_pixel,
  output      logic [DEST_W-1:0]      dest_index
);

  // Derived geometry and widths
  localparam int SrcDepth = SRC_WIDTH * SRC_HEIGHT;
  localparam int AW       = $clog2(SrcDepth);
  localparam int OfsMaxX  = ((1 << X_W) > WIN_WIDTH / 2) ? (1 << X_W) : WIN_WIDTH / 2;
  localparam int OfsMaxY  = ((1 << Y_W) > WIN_HEIGHT / 2) ? (1 << Y_W) : WIN_HEIGHT / 2;
  localparam int OfsMax   = (OfsMaxX > OfsMaxY) ? OfsMaxX : OfsMaxY;
  localparam int OfsW     = $clog2(OfsMax + 1) + 1;
  localparam int ProdW    = OfsW + TRIG_W;
  localparam int SumW     = ProdW + 1;
  localparam int SrcMax   = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int CoordA   = SumW - Q_SHIFT;
  localparam int CoordB   = $clog2(SrcMax) + 1;
  localparam int CoordW   = ((CoordA > CoordB) ? CoordA : CoordB) + 1;
  localparam int SwW      = $clog2(SRC_WIDTH + 1) + 1;
  localparam int RotW     = CoordW + SwW + 1;
  localparam int CropMax  = (WIN_HEIGHT / 2 + (1 << Y_W)) * SRC_WIDTH + (1 << X_W)
                            + WIN_WIDTH / 2;
  localparam int CropA    = $clog2(CropMax + 1);
  localparam int CropW    = (CropA > AW + 1) ? CropA : AW + 1;
  localparam int DestA    = $clog2((1 << Y_W) * WIN_WIDTH + WIN_WIDTH) + 1;
  localparam int DestFW   = (DestA > DEST_W) ? DestA : DEST_W;
  localparam int WinArea  = WIN_WIDTH * WIN_HEIGHT;

  logic accept;
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [TRIG_W-1:0] sin_q;

  // stage 1: input register
  logic                   s1_valid;
  logic [CMD_W-1:0]       s1_cmd;
  logic [LOAD_ADDR_W-1:0] s1_laddr;
  logic [PIX_W-1:0]       s1_pix;
  logic [X_W-1:0]         s1_x;
  logic [Y_W-1:0]         s1_y;

  // stage 2: products
  logic                    s2_load, s2_sample;
  logic [LOAD_ADDR_W-1:0]  s2_laddr;
  logic [PIX_W-1:0]        s2_pix;
  logic signed [ProdW-1:0] s2_xc, s2_ys, s2_xs, s2_yc;
  logic [CropW-1:0]        s2_crop;
  logic [DEST_W-1:0]       s2_dest;

  // stage 3: source coordinates
  logic                     s3_load, s3_sample;
  logic [LOAD_ADDR_W-1:0]   s3_laddr;
  logic [PIX_W-1:0]         s3_pix;
  logic signed [CoordW-1:0] s3_sx, s3_sy;
  logic [CropW-1:0]         s3_crop;
  logic [DEST_W-1:0]        s3_dest;

  // stage 4: store addresses
  logic                   s4_load, s4_sample;
  logic [LOAD_ADDR_W-1:0] s4_laddr;
  logic [PIX_W-1:0]       s4_pix;
  logic signed [RotW-1:0] s4_rot;
  logic [CropW-1:0]       s4_crop;
  logic                   s4_crop_ok;
  logic [DEST_W-1:0]      s4_dest;

  // stage 5: store read data
  logic                   s5_rot_ok, s5_crop_ok;
  logic [PIX_W-1:0]       rd_rot, rd_crop;

  logic signed [OfsW-1:0]   dx, dy;
  logic signed [SumW-1:0]   sum_x, sum_y;
  logic signed [CoordW-1:0] sx_next, sy_next;
  logic signed [RotW-1:0]   rot_next;
  logic [CropW-1:0]         crop_next;
  logic [DestFW-1:0]        dest_full;
  logic                     load_ok, sample_ok;

  // Handshakes: commands flow every cycle outside reset, config writes always taken
  assign busy      = rst;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Hold the rotation registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_q <= COS_RESET;
      sin_q <= SIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_COS: cos_q <= signed'(cfg_data);
        CFG_SIN: sin_q <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Capture the accepted command
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_cmd   <= command;
    s1_laddr <= load_address;
    s1_pix   <= pixel_value;
    s1_x     <= out_x;
    s1_y     <= out_y;
  end

  // Classify the command, form window offsets, crop address and mirrored index
  always_comb begin
    load_ok   = s1_valid && (s1_cmd == CMD_LOAD) && (int'(s1_laddr) < SrcDepth);
    sample_ok = s1_valid && (s1_cmd == CMD_SAMPLE) && (int'(s1_x) < WIN_WIDTH)
                && (int'(s1_y) < WIN_HEIGHT);
    dx = signed'(OfsW'(s1_x)) - signed'(OfsW'(WIN_WIDTH / 2));
    dy = signed'(OfsW'(s1_y)) - signed'(OfsW'(WIN_HEIGHT / 2));
    crop_next = (CropW'(WIN_HEIGHT / 2) + CropW'(s1_y)) * CropW'(SRC_WIDTH)
                + CropW'(s1_x) + CropW'(WIN_WIDTH / 2);
    dest_full = DestFW'(s1_y) * DestFW'(WIN_WIDTH) + DestFW'(WIN_WIDTH - 1)
                - DestFW'(s1_x);
  end

  // Multiply offsets by the trig pair
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_load   <= 1'b0;
      s2_sample <= 1'b0;
    end else begin
      s2_load   <= load_ok;
      s2_sample <= sample_ok;
    end
    s2_laddr <= s1_laddr;
    s2_pix   <= s1_pix;
    s2_xc    <= ProdW'(dx) * ProdW'(cos_q);
    s2_ys    <= ProdW'(dy) * ProdW'(sin_q);
    s2_xs    <= ProdW'(dx) * ProdW'(sin_q);
    s2_yc    <= ProdW'(dy) * ProdW'(cos_q);
    s2_crop  <= crop_next;
    s2_dest  <= dest_full[DEST_W-1:0];
  end

  // Rotate, floor by arithmetic shift, recentre on the source
  always_comb begin
    sum_x   = SumW'(s2_xc) - SumW'(s2_ys);
    sum_y   = SumW'(s2_xs) + SumW'(s2_yc);
    sx_next = CoordW'(sum_x >>> Q_SHIFT) + CoordW'(SRC_WIDTH / 2);
    sy_next = CoordW'(sum_y >>> Q_SHIFT) + CoordW'(SRC_HEIGHT / 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_load   <= 1'b0;
      s3_sample <= 1'b0;
    end else begin
      s3_load   <= s2_load;
      s3_sample <= s2_sample;
    end
    s3_laddr <= s2_laddr;
    s3_pix   <= s2_pix;
    s3_sx    <= sx_next;
    s3_sy    <= sy_next;
    s3_crop  <= s2_crop;
    s3_dest  <= s2_dest;
  end

  // Linear address of the pixel one row below the rotated point
  assign rot_next = RotW'(s3_sy) * RotW'(SRC_WIDTH) + RotW'(s3_sx) + RotW'(SRC_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_load   <= 1'b0;
      s4_sample <= 1'b0;
    end else begin
      s4_load   <= s3_load;
      s4_sample <= s3_sample;
    end
    s4_laddr   <= s3_laddr;
    s4_pix     <= s3_pix;
    s4_rot     <= rot_next;
    s4_crop    <= s3_crop;
    s4_crop_ok <= s3_crop < CropW'(SrcDepth);
    s4_dest    <= s3_dest;
  end

  // Frame store: loads write at the same stage that samples read
  rcfs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (SrcDepth)
  ) u_store (
    .clk       (clk),
    .wr_en     (s4_load),
    .wr_addr   (AW'(s4_laddr)),
    .wr_data   (s4_pix),
    .rd_addr_a (s4_rot[AW-1:0]),
    .rd_data_a (rd_rot),
    .rd_addr_b (s4_crop[AW-1:0]),
    .rd_data_b (rd_crop)
  );

  // Present the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s4_sample;
    end
    s5_rot_ok  <= !s4_rot[RotW-1] && (s4_rot < RotW'(SrcDepth));
    s5_crop_ok <= s4_crop_ok;
    dest_index <= s4_dest;
  end

  // Zero out reads that fell outside the store
  assign rotated_pixel = s5_rot_ok  ? rd_rot  : '0;
  assign cropped_pixel = s5_crop_ok ? rd_crop : '0;

  // A captured sample inside the window yields a result_valid pulse
  a_sample_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_cmd == CMD_SAMPLE) && (int'(s1_x) < WIN_WIDTH)
     && (int'(s1_y) < WIN_HEIGHT)) |-> ##4 result_valid)
    else $error("window sample produced no result");

  // Every store write comes from a captured load, carried through the product, coordinate and address registers
  a_write_origin: assert property (@(posedge clk) disable iff (rst)
    s4_load |-> $past(s1_valid && (s1_cmd == CMD_LOAD), 3))
    else $error("store write without a matching load");

  // Mirrored index stays inside the window buffer
  a_dest_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((int'(dest_index) < WinArea) || (WinArea > (1 << DEST_W))))
    else $error("mirrored index outside the window buffer");

endmodule

`default_nettype wire
